[rtl/arp_age_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ARP cache table package
// Shared sizes, action codes and item types of the ARP cache table.
// ----------------------------------------------------------------------------
package arp_age_pkg;

   localparam int ENTRIES = 8;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int IP_W    = 32;
   localparam int MAC_W   = 48;
   localparam int STAMP_W = 8;
   localparam int SLOT_W  = 3;
   localparam int CNT_W   = 4;

   localparam logic [STAMP_W-1:0] MAX_AGE_RESET = 8'd120;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_HIT   = 2'd1,
      ACT_FREE  = 2'd2,
      ACT_EVICT = 2'd3
   } action_type;

   typedef enum logic {
      CMD_TICK   = 1'b0,
      CMD_UPDATE = 1'b1
   } cmd_type;

   typedef struct packed {
      logic             cmd;
      logic [IP_W-1:0]  ip_addr;
      logic [MAC_W-1:0] mac_addr;
   } req_type;

   typedef struct packed {
      action_type        action;
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0]  expired_count;
   } rsp_type;

endpackage
`default_nettype wire

[rtl/arp_cache_table_aging.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ARP cache table with aging and oldest-entry eviction
// Usage:
// An item is taken at a rising edge with start high and busy low. A tick item
// advances the 8-bit clock and clears every valid entry whose age has reached
// max_age. An update item rewrites a matching entry, fills the lowest free
// slot, or evicts the oldest entry.
// One comparator and one age subtractor visit one slot per cycle, so an item
// keeps busy high while ST_SCAN visits every slot and then while ST_DONE writes
// back. The result is shown for exactly one cycle with rsp_valid high, in the
// first cycle with busy low; a new item may be taken in that same cycle. The
// block takes no new item until it has formed the result of the last one.
// The receiver cannot stall; each result must be taken when it is shown.
// The max_age register is written through csr_valid / csr_data; csr_ready is
// always high, and writes are meant to happen while the block is idle.
// Reset empties the table, clears the clock and sets max_age to 120.
// ----------------------------------------------------------------------------
module arp_cache_table_aging (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire arp_age_pkg::req_type                   req_data,
   output logic                                        rsp_valid,
   output arp_age_pkg::rsp_type                        rsp_data,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [arp_age_pkg::STAMP_W-1:0]        csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   localparam logic [arp_age_pkg::IDX_W-1:0] LAST_IDX =
      arp_age_pkg::IDX_W'(arp_age_pkg::ENTRIES - 1);

   logic [arp_age_pkg::IP_W-1:0]    entry_ip_ff    [arp_age_pkg::ENTRIES];
   logic [arp_age_pkg::MAC_W-1:0]   entry_mac_ff   [arp_age_pkg::ENTRIES];
   logic [arp_age_pkg::STAMP_W-1:0] entry_stamp_ff [arp_age_pkg::ENTRIES];

   state_type                       state_ff, state_in;
   logic [arp_age_pkg::STAMP_W-1:0] clock_now_ff, clock_now_in;
   logic [arp_age_pkg::STAMP_W-1:0] max_age_ff;
   logic [arp_age_pkg::IDX_W-1:0]   idx_ff, idx_in;
   arp_age_pkg::req_type            req_ff;

   logic                            hit_found_ff, hit_found_in;
   logic [arp_age_pkg::IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic                            free_found_ff, free_found_in;
   logic [arp_age_pkg::IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [arp_age_pkg::STAMP_W-1:0] best_age_ff, best_age_in;
   logic [arp_age_pkg::IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [arp_age_pkg::CNT_W-1:0]   count_ff, count_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   arp_age_pkg::rsp_type            rsp_ff, rsp_in;

   logic                            accept;
   logic                            cur_valid;
   logic [arp_age_pkg::STAMP_W-1:0] cur_age;
   logic                            is_tick;
   logic                            clear_en;
   logic                            write_en;
   logic [arp_age_pkg::IDX_W-1:0]   write_idx;
   logic [arp_age_pkg::IDX_W+arp_age_pkg::SLOT_W-1:0] slot_wide;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign is_tick   = (req_ff.cmd == arp_age_pkg::CMD_TICK);
   assign cur_valid = (entry_ip_ff[idx_ff] != '0);
   assign cur_age   = clock_now_ff - entry_stamp_ff[idx_ff];
   assign clear_en  = (state_ff == ST_SCAN) && is_tick && cur_valid &&
                      (cur_age >= max_age_ff);
   assign write_en  = (state_ff == ST_DONE) && !is_tick;

   always_comb begin
      if (hit_found_ff) begin
         write_idx = hit_idx_ff;
      end else if (free_found_ff) begin
         write_idx = free_idx_ff;
      end else begin
         write_idx = best_idx_ff;
      end
   end

   assign slot_wide = {{arp_age_pkg::SLOT_W{1'b0}}, write_idx};

   always_comb begin
      state_in      = state_ff;
      clock_now_in  = clock_now_ff;
      idx_in        = idx_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_age_in   = best_age_ff;
      best_idx_in   = best_idx_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in      = ST_SCAN;
               idx_in        = '0;
               hit_found_in  = 1'b0;
               hit_idx_in    = '0;
               free_found_in = 1'b0;
               free_idx_in   = '0;
               best_age_in   = '0;
               best_idx_in   = '0;
               count_in      = '0;
               if (req_data.cmd == arp_age_pkg::CMD_TICK) begin
                  clock_now_in = clock_now_ff + 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (clear_en && (count_ff != '1)) begin
               count_in = count_ff + 1'b1;
            end
            if (!hit_found_ff && cur_valid && (entry_ip_ff[idx_ff] == req_ff.ip_addr)) begin
               hit_found_in = 1'b1;
               hit_idx_in   = idx_ff;
            end
            if (!free_found_ff && !cur_valid) begin
               free_found_in = 1'b1;
               free_idx_in   = idx_ff;
            end
            if (cur_age > best_age_ff) begin
               best_age_in = cur_age;
               best_idx_in = idx_ff;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (is_tick) begin
               rsp_in.action        = arp_age_pkg::ACT_TICK;
               rsp_in.slot          = '0;
               rsp_in.expired_count = count_ff;
            end else begin
               if (hit_found_ff) begin
                  rsp_in.action = arp_age_pkg::ACT_HIT;
               end else if (free_found_ff) begin
                  rsp_in.action = arp_age_pkg::ACT_FREE;
               end else begin
                  rsp_in.action = arp_age_pkg::ACT_EVICT;
               end
               rsp_in.slot          = slot_wide[arp_age_pkg::SLOT_W-1:0];
               rsp_in.expired_count = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clock_now_ff <= '0;
         max_age_ff   <= arp_age_pkg::MAX_AGE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_now_ff <= clock_now_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            max_age_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      best_age_ff   <= best_age_in;
      best_idx_ff   <= best_idx_in;
      count_ff      <= count_in;
      rsp_ff        <= rsp_in;
      if (accept) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < arp_age_pkg::ENTRIES; k++) begin
            entry_ip_ff[k] <= '0;
         end
      end else if (clear_en) begin
         entry_ip_ff[idx_ff] <= '0;
      end else if (write_en) begin
         entry_ip_ff[write_idx] <= req_ff.ip_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         entry_mac_ff[write_idx]   <= req_ff.mac_addr;
         entry_stamp_ff[write_idx] <= clock_now_ff;
      end
   end

endmodule
`default_nettype wire

[rtl/arp_age_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ARP cache table port checker
// Watches the ports of the ARP cache table for sequencing and result rules.
// ----------------------------------------------------------------------------
module arp_age_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire logic                 rsp_valid,
   input wire arp_age_pkg::rsp_type rsp_data
);

   // An accepted item always makes the block busy on the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // A result follows a busy period and is shown once the block is free.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result shown outside the end of a busy period");

   // A result is a single-cycle strobe.
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // A tick result carries no slot; an update result carries no count.
   a_tick_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.action == arp_age_pkg::ACT_TICK)) |->
         (rsp_data.slot == '0))
      else $error("tick result with nonzero slot");

   a_update_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.action != arp_age_pkg::ACT_TICK)) |->
         (rsp_data.expired_count == '0))
      else $error("update result with nonzero expired count");

endmodule

bind arp_cache_table_aging arp_age_checker u_arp_age_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire
